### rtl/core/signed_128bit_divide_remainder_core_defines.svh
// Assertion macros shared by the divider core.
`ifndef SIGNED_128BIT_DIVIDE_REMAINDER_CORE_DEFINES_SVH
`define SIGNED_128BIT_DIVIDE_REMAINDER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SBDR_CHECK(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SBDR_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sbdr_pkg.sv
package sbdr_pkg;

    localparam int HALF_BITS = 64;
    localparam int FULL_BITS = 128;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DIV_ZERO = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic finish;
    } sbdr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_zero;
    } sbdr_stat_t;

endpackage

### rtl/core/sbdr_ctrl.sv
module sbdr_ctrl #(
    parameter int DATA_BITS = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sbdr_pkg::sbdr_stat_t stat,
    output sbdr_pkg::sbdr_cmd_t  cmd,
    output logic               busy,
    output logic               done
);

    localparam int CNT_W = $clog2(DATA_BITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_FIX  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
                cnt_next = CNT_W'(DATA_BITS - 1);
                // A zero divisor skips the iterations altogether.
                state_next = stat.div_zero ? ST_FIX : ST_RUN;
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FIX:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

### rtl/core/sbdr_dpath.sv
module sbdr_dpath #(
    parameter int DATA_BITS = 128
) (
    input  logic                                 clk,
    input  sbdr_pkg::sbdr_cmd_t                  cmd,
    output sbdr_pkg::sbdr_stat_t                 stat,
    input  logic [sbdr_pkg::FULL_BITS-1:0]       dividend,
    input  logic [sbdr_pkg::FULL_BITS-1:0]       divisor,
    output logic [sbdr_pkg::FULL_BITS-1:0]       quotient,
    output logic [sbdr_pkg::FULL_BITS-1:0]       remainder,
    output logic                                 status
);

    localparam int N = DATA_BITS;

    logic [N-1:0] num_reg, num_next;
    logic [N-1:0] den_reg, den_next;
    logic [N-1:0] rem_reg, rem_next;
    logic         n_neg_reg, n_neg_next;
    logic         d_neg_reg, d_neg_next;

    logic [sbdr_pkg::FULL_BITS-1:0] quo_reg, quo_next;
    logic [sbdr_pkg::FULL_BITS-1:0] rmd_reg, rmd_next;
    logic                           status_reg, status_next;

    logic [N:0]   trial;
    logic [N+1:0] diff;
    logic         borrow;
    logic [N-1:0] q_fix;
    logic [N-1:0] r_fix;

    assign stat.div_zero = (den_reg == '0);

    // One restoring step: the next dividend bit enters the partial remainder
    // and the quotient bit fills the vacated low end of num_reg.
    assign trial  = {rem_reg, num_reg[N-1]};
    assign diff   = {1'b0, trial} - {2'b00, den_reg};
    assign borrow = diff[N+1];

    assign q_fix = (n_neg_reg ^ d_neg_reg) ? (N'(0) - num_reg) : num_reg;
    assign r_fix = n_neg_reg ? (N'(0) - rem_reg) : rem_reg;

    always_comb
    begin
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        n_neg_next  = n_neg_reg;
        d_neg_next  = d_neg_reg;
        quo_next    = quo_reg;
        rmd_next    = rmd_reg;
        status_next = status_reg;
        if (cmd.load)
        begin
            num_next   = dividend[N-1:0];
            den_next   = divisor[N-1:0];
            n_neg_next = dividend[N-1];
            d_neg_next = divisor[N-1];
        end
        if (cmd.prep)
        begin
            num_next = n_neg_reg ? (N'(0) - num_reg) : num_reg;
            den_next = d_neg_reg ? (N'(0) - den_reg) : den_reg;
            rem_next = '0;
        end
        if (cmd.step)
        begin
            rem_next = borrow ? trial[N-1:0] : diff[N-1:0];
            num_next = {num_reg[N-2:0], ~borrow};
        end
        if (cmd.finish)
        begin
            if (stat.div_zero)
            begin
                quo_next    = '0;
                rmd_next    = '0;
                status_next = sbdr_pkg::STATUS_DIV_ZERO;
            end
            else
            begin
                quo_next    = sbdr_pkg::FULL_BITS'($signed(q_fix));
                rmd_next    = sbdr_pkg::FULL_BITS'($signed(r_fix));
                status_next = sbdr_pkg::STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        n_neg_reg  <= n_neg_next;
        d_neg_reg  <= d_neg_next;
        quo_reg    <= quo_next;
        rmd_reg    <= rmd_next;
        status_reg <= status_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rmd_reg;
    assign status    = status_reg;

endmodule

### rtl/core/signed_128bit_divide_remainder_core.sv
// Signed 128-bit divider with remainder.
// An operation starts with a transfer at a rising edge where start is high and
// busy is low; the four operand halves are sampled at that edge. The operands are
// cut to DATA_BITS bits and taken as two's complement values.
// busy stays high for the whole operation: a prep state forms the magnitudes, the
// restoring shift-subtract loop runs one quotient bit per cycle, and a fix state
// applies the signs. A zero divisor skips the loop and goes from prep to fix.
// The next start can be taken no earlier than the edge that ends the result cycle,
// so the block takes no new operation while one is in flight.
// The result is on the output ports for one cycle marked by done, the first cycle
// with busy low. The receiver cannot stall that transfer; a result that is not taken
// is lost, and the ports keep their last value until the next result.
// The quotient is truncated toward zero, the remainder takes the dividend's sign,
// and both are sign-extended to 128 bits. A zero divisor gives status 1 with a
// zero quotient and remainder; the most negative value divided by minus one wraps.
// Reset clears the controller and the done strobe; an operation in flight is lost.
`include "signed_128bit_divide_remainder_core_defines.svh"

module signed_128bit_divide_remainder_core #(
    parameter int DATA_BITS = 128
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  logic signed [sbdr_pkg::HALF_BITS-1:0]     dividend_high,
    input  logic        [sbdr_pkg::HALF_BITS-1:0]     dividend_low,
    input  logic signed [sbdr_pkg::HALF_BITS-1:0]     divisor_high,
    input  logic        [sbdr_pkg::HALF_BITS-1:0]     divisor_low,
    output logic                                      done,
    output logic signed [sbdr_pkg::HALF_BITS-1:0]     quotient_high,
    output logic        [sbdr_pkg::HALF_BITS-1:0]     quotient_low,
    output logic signed [sbdr_pkg::HALF_BITS-1:0]     remainder_high,
    output logic        [sbdr_pkg::HALF_BITS-1:0]     remainder_low,
    output logic                                      status
);

    sbdr_pkg::sbdr_cmd_t  cmd;
    sbdr_pkg::sbdr_stat_t stat;

    logic [sbdr_pkg::FULL_BITS-1:0] quotient;
    logic [sbdr_pkg::FULL_BITS-1:0] remainder;

    sbdr_ctrl #(
        .DATA_BITS(DATA_BITS)
    ) u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .stat (stat),
        .cmd  (cmd),
        .busy (busy),
        .done (done)
    );

    sbdr_dpath #(
        .DATA_BITS(DATA_BITS)
    ) u_dpath (
        .clk      (clk),
        .cmd      (cmd),
        .stat     (stat),
        .dividend ({dividend_high, dividend_low}),
        .divisor  ({divisor_high, divisor_low}),
        .quotient (quotient),
        .remainder(remainder),
        .status   (status)
    );

    assign quotient_high  = $signed(quotient[sbdr_pkg::FULL_BITS-1:sbdr_pkg::HALF_BITS]);
    assign quotient_low   = quotient[sbdr_pkg::HALF_BITS-1:0];
    assign remainder_high = $signed(remainder[sbdr_pkg::FULL_BITS-1:sbdr_pkg::HALF_BITS]);
    assign remainder_low  = remainder[sbdr_pkg::HALF_BITS-1:0];

    `SBDR_CHECK(a_done_when_idle, done, !busy, "result strobe while an operation is running")
    `SBDR_CHECK_NEXT(a_start_goes_busy, start && !busy, busy, "accepted start did not raise busy")
    `SBDR_CHECK_NEXT(a_done_single, done, !done, "result strobe lasted more than one cycle")
    `SBDR_CHECK(a_zero_div_result, done && status, {quotient, remainder} == '0, "bad zero divide")

endmodule
